// ----- rtl/det_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the diagnostic event table.
package det_pkg;

  localparam int EVENTS_DEF  = 32;
  localparam int FUNC_W      = 3;
  localparam int EIDX_W      = 8;
  localparam int CODE_W      = 24;
  localparam int OIDX_W      = 5;
  localparam int STAT_W      = 8;
  localparam int OCC_W       = 32;
  localparam int SRC_W       = 8;
  localparam int CNT_W       = 8;
  localparam int FTHR_W      = 7;
  localparam int PTHR_W      = 8;
  localparam int ST_W        = 3;
  localparam int CMP_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int MAX_FRAMES  = 32;
  localparam int FRM_CNT_W   = 6;

  localparam int ST_TF   = 0;
  localparam int ST_PEND = 1;
  localparam int ST_CONF = 2;

  localparam logic [SRC_W-1:0]  ECU_ID_RST   = 8'h00;
  localparam logic [FTHR_W-1:0] FAIL_THR_RST = 7'd3;
  localparam logic [PTHR_W-1:0] PASS_THR_RST = 8'hFD;

  typedef enum logic [FUNC_W-1:0] {
    FN_REPORT = 3'd0,
    FN_QUERY  = 3'd1,
    FN_CLEAR  = 3'd2,
    FN_SCAN   = 3'd3,
    FN_CODE   = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECU_ID   = 2'd0,
    CFG_FAIL_THR = 2'd1,
    CFG_PASS_THR = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP1,
    ST_STEP2,
    ST_WRITE,
    ST_CODE,
    ST_RESP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END
  } fsm_e;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [ST_W-1:0]  st;
    logic [OCC_W-1:0] occ;
    logic             sent;
  } ent_t;

  typedef struct packed {
    logic              ok;
    logic              frame;
    logic [OIDX_W-1:0] entry_index;
    logic [STAT_W-1:0] status_bits;
    logic [OCC_W-1:0]  occurrences;
    logic [CODE_W-1:0] fault_code;
    logic [SRC_W-1:0]  source_id;
    logic              last;
  } res_t;

  function automatic logic [CODE_W-1:0] det_default_code(input logic [EIDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    case (idx)
      8'd0:    code = 24'hC00100;
      8'd1:    code = 24'hC00200;
      8'd2:    code = 24'hC00300;
      8'd3:    code = 24'hC00400;
      8'd4:    code = 24'hC10100;
      8'd5:    code = 24'hC10200;
      8'd6:    code = 24'hC10300;
      8'd7:    code = 24'hC20100;
      8'd8:    code = 24'hC20200;
      8'd9:    code = 24'hC20300;
      8'd10:   code = 24'hC30100;
      8'd11:   code = 24'hC30200;
      8'd12:   code = 24'hC40100;
      8'd13:   code = 24'hC50100;
      8'd14:   code = 24'hC50200;
      8'd15:   code = 24'hC60100;
      8'd16:   code = 24'hC60200;
      8'd17:   code = 24'hC70100;
      default: code = '0;
    endcase
    return code;
  endfunction

  function automatic logic [STAT_W-1:0] det_status_byte(input logic [ST_W-1:0] st);
    return {4'b0000, st[ST_CONF], st[ST_PEND], 1'b0, st[ST_TF]};
  endfunction

endpackage

// ----- rtl/det_in_if.sv -----
`timescale 1ns / 1ps
// Request channel of the diagnostic event table.
interface det_in_if;
  import det_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [EIDX_W-1:0] event_index;
  logic              failed;
  logic [CODE_W-1:0] code_value;

  modport source(output valid, func, event_index, failed, code_value, input ready);
  modport sink(input valid, func, event_index, failed, code_value, output ready);
endinterface

// ----- rtl/det_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the diagnostic event table.
interface det_out_if;
  import det_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic              frame;
  logic [OIDX_W-1:0] entry_index;
  logic [STAT_W-1:0] status_bits;
  logic [OCC_W-1:0]  occurrences;
  logic [CODE_W-1:0] fault_code;
  logic [SRC_W-1:0]  source_id;
  logic              last;

  modport source(output valid, ok, frame, entry_index, status_bits, occurrences,
                 fault_code, source_id, last, input ready);
  modport sink(input valid, ok, frame, entry_index, status_bits, occurrences,
               fault_code, source_id, last, output ready);
endinterface

// ----- rtl/det_cfg_if.sv -----
`timescale 1ns / 1ps
// Register write channel of the diagnostic event table.
interface det_cfg_if;
  import det_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/det_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module det_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/diagnostic_event_table_core.sv -----
`timescale 1ns / 1ps
// Top level of the diagnostic event table: sequencer, shared update unit and entry storage.
//
// The block takes one request at a time and holds ready low until its sequencer is back in
// idle; a finished result waits in the output register, so the next request can be taken
// while it is still pending. Every entry access goes through one read port of the entry RAM
// and one shared adder/comparator. A report passes load, the update steps and a write before
// its response, and a scan reads and checks each entry in turn and can stall on the output.
// Entry state and codes live in RAM with per-entry valid bits, so reset and clear-all take
// effect at once with no clearing pass; an entry whose code was never written reads its
// default fault code.
module diagnostic_event_table_core #(
  parameter int EVENTS = det_pkg::EVENTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  det_in_if.sink    in_if,
  det_out_if.source out_if,
  det_cfg_if.sink   cfg_if
);
  import det_pkg::*;

  localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int LIM_W = EIDX_W + 1;
  localparam int ENT_W = $bits(ent_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EVENTS - 1);
  localparam logic [LIM_W-1:0] EVENTS_LIM = LIM_W'(EVENTS);
  localparam logic [OCC_W-1:0] ONE = OCC_W'(1);
  localparam logic [OCC_W-1:0] MINUS_ONE = {OCC_W{1'b1}};
  localparam logic [FRM_CNT_W-1:0] FRM_LIM = FRM_CNT_W'(MAX_FRAMES);

  fsm_e state_q, state_d;

  logic [SRC_W-1:0]  ecu_id_q;
  logic [FTHR_W-1:0] fail_thr_q;
  logic [PTHR_W-1:0] pass_thr_q;

  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  idx_q;
  logic              failed_q;
  logic [CODE_W-1:0] code_in_q;
  logic              err_q;

  logic [CNT_W-1:0]  cnt_q;
  logic [ST_W-1:0]   st_q;
  logic [OCC_W-1:0]  occ_q;
  logic              sent_q;

  logic [EVENTS-1:0] ent_vld_q;
  logic [EVENTS-1:0] code_vld_q;

  logic              hold_q;
  logic [IDX_W-1:0]  hold_idx_q;
  logic [ST_W-1:0]   hold_st_q;
  logic [OCC_W-1:0]  hold_occ_q;
  logic [CODE_W-1:0] hold_code_q;
  logic [FRM_CNT_W-1:0] nfrm_q;

  logic out_vld_q;
  res_t res_q, res_d;
  logic out_load, out_free;

  logic in_acc, idx_ok, req_err;

  logic [IDX_W-1:0]  raddr;
  logic [ENT_W-1:0]  ent_rdata, ent_wdata;
  logic              ent_we;
  logic [CODE_W-1:0] code_rdata;
  logic              code_we;
  ent_t              ent_rd, ent_wr;
  logic [CODE_W-1:0] code_rd;

  logic [OCC_W-1:0]        alu_a, alu_b, alu_sum;
  logic signed [CMP_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;
  logic                    cnt_nonpos;

  logic elig, chk_go;

  assign in_acc = in_if.valid && in_if.ready;
  assign idx_ok = {1'b0, in_if.event_index} < EVENTS_LIM;
  assign out_free = !out_vld_q || out_if.ready;

  always_comb begin
    case (in_if.func)
      FN_REPORT, FN_QUERY, FN_CODE: req_err = !idx_ok;
      FN_CLEAR, FN_SCAN:            req_err = 1'b0;
      default:                      req_err = 1'b1;
    endcase
  end

  assign raddr = (state_q == ST_IDLE) ? in_if.event_index[IDX_W-1:0] : idx_q;

  det_ram #(.WIDTH(ENT_W), .DEPTH(EVENTS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (idx_q),
    .wdata_i (ent_wdata),
    .raddr_i (raddr),
    .rdata_o (ent_rdata)
  );

  det_ram #(.WIDTH(CODE_W), .DEPTH(EVENTS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (idx_q),
    .wdata_i (code_in_q),
    .raddr_i (raddr),
    .rdata_o (code_rdata)
  );

  assign ent_rd  = ent_vld_q[idx_q] ? ent_t'(ent_rdata) : '0;
  assign code_rd = code_vld_q[idx_q] ? code_rdata : det_default_code(EIDX_W'(idx_q));

  // Shared update unit: one wide adder and one signed compare.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      ST_STEP1: begin
        alu_a = {{(OCC_W-CNT_W){cnt_q[CNT_W-1]}}, cnt_q};
        alu_b = failed_q ? ONE : MINUS_ONE;
      end
      ST_STEP2: begin
        alu_a = occ_q;
        alu_b = ONE;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
    if (failed_q) begin
      cmp_a = {cnt_q[CNT_W-1], cnt_q};
      cmp_b = {2'b00, fail_thr_q};
    end else begin
      cmp_a = {pass_thr_q[PTHR_W-1], pass_thr_q};
      cmp_b = {cnt_q[CNT_W-1], cnt_q};
    end
  end

  assign alu_sum    = alu_a + alu_b;
  assign cmp_lt     = cmp_a < cmp_b;
  assign cnt_nonpos = cnt_q[CNT_W-1] || (cnt_q == '0);

  assign elig = ent_rd.st[ST_CONF] && !ent_rd.sent && (code_rd != '0) && (nfrm_q < FRM_LIM);
  assign chk_go = !elig || !hold_q || out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_err) begin
            state_d = ST_RESP;
          end else begin
            case (in_if.func)
              FN_REPORT, FN_QUERY: state_d = ST_LOAD;
              FN_CODE:             state_d = ST_CODE;
              FN_SCAN:             state_d = ST_SCAN_RD;
              default:             state_d = ST_RESP;
            endcase
          end
        end
      end
      ST_LOAD:     state_d = (func_q == FN_REPORT) ? ST_STEP1 : ST_RESP;
      ST_STEP1:    state_d = ST_STEP2;
      ST_STEP2:    state_d = ST_WRITE;
      ST_WRITE:    state_d = ST_RESP;
      ST_CODE:     state_d = ST_RESP;
      ST_RESP:     state_d = out_free ? ST_IDLE : ST_RESP;
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (chk_go) begin
          state_d = (idx_q == LAST_IDX) ? ST_SCAN_END : ST_SCAN_RD;
        end
      end
      ST_SCAN_END: state_d = out_free ? ST_IDLE : ST_SCAN_END;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ent_we   = 1'b0;
    code_we  = 1'b0;
    ent_wr   = '0;
    out_load = 1'b0;
    res_d    = '0;
    res_d.last = 1'b1;
    case (state_q)
      ST_WRITE: begin
        ent_we = 1'b1;
        ent_wr = '{cnt: cnt_q, st: st_q, occ: occ_q, sent: sent_q};
      end
      ST_CODE: begin
        code_we = 1'b1;
      end
      ST_RESP: begin
        out_load = out_free;
        if (!err_q) begin
          case (func_q)
            FN_REPORT, FN_QUERY: begin
              res_d.ok          = 1'b1;
              res_d.entry_index = OIDX_W'(idx_q);
              res_d.status_bits = det_status_byte(st_q);
              res_d.occurrences = occ_q;
            end
            FN_CLEAR: res_d.ok = 1'b1;
            FN_CODE: begin
              res_d.ok          = 1'b1;
              res_d.entry_index = OIDX_W'(idx_q);
            end
            default: res_d.ok = 1'b0;
          endcase
        end
      end
      ST_SCAN_CHK: begin
        ent_we = elig && chk_go;
        ent_wr = ent_rd;
        ent_wr.sent = 1'b1;
        out_load = elig && hold_q && out_free;
        res_d = '{ok: 1'b1, frame: 1'b1, entry_index: OIDX_W'(hold_idx_q),
                  status_bits: det_status_byte(hold_st_q), occurrences: hold_occ_q,
                  fault_code: hold_code_q, source_id: ecu_id_q, last: 1'b0};
      end
      ST_SCAN_END: begin
        out_load = out_free;
        if (hold_q) begin
          res_d = '{ok: 1'b1, frame: 1'b1, entry_index: OIDX_W'(hold_idx_q),
                    status_bits: det_status_byte(hold_st_q), occurrences: hold_occ_q,
                    fault_code: hold_code_q, source_id: ecu_id_q, last: 1'b1};
        end
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
  end

  assign ent_wdata = ent_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ecu_id_q   <= ECU_ID_RST;
      fail_thr_q <= FAIL_THR_RST;
      pass_thr_q <= PASS_THR_RST;
      ent_vld_q  <= '0;
      code_vld_q <= '0;
      hold_q     <= 1'b0;
      nfrm_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_load || (out_vld_q && !out_if.ready);
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CFG_ECU_ID:   ecu_id_q   <= cfg_if.data;
          CFG_FAIL_THR: fail_thr_q <= cfg_if.data[FTHR_W-1:0];
          CFG_PASS_THR: pass_thr_q <= cfg_if.data;
          default:      ecu_id_q   <= ecu_id_q;
        endcase
      end
      if (in_acc) begin
        hold_q <= 1'b0;
        nfrm_q <= '0;
        if (in_if.func == FN_CLEAR) begin
          ent_vld_q <= '0;
        end
      end
      if (ent_we) begin
        ent_vld_q[idx_q] <= 1'b1;
      end
      if (code_we) begin
        code_vld_q[idx_q] <= 1'b1;
      end
      if (state_q == ST_SCAN_CHK && elig && chk_go) begin
        hold_q <= 1'b1;
        nfrm_q <= nfrm_q + FRM_CNT_W'(1);
      end
      if (state_q == ST_SCAN_END && out_free) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= in_if.func;
      failed_q  <= in_if.failed;
      code_in_q <= in_if.code_value;
      err_q     <= req_err;
      idx_q     <= (in_if.func == FN_SCAN) ? '0 : in_if.event_index[IDX_W-1:0];
    end
    case (state_q)
      ST_LOAD: begin
        cnt_q  <= ent_rd.cnt;
        st_q   <= ent_rd.st;
        occ_q  <= ent_rd.occ;
        sent_q <= ent_rd.sent;
      end
      ST_STEP1: begin
        if (cmp_lt) begin
          cnt_q <= alu_sum[CNT_W-1:0];
        end
        if (failed_q) begin
          st_q[ST_TF]   <= 1'b1;
          st_q[ST_PEND] <= 1'b1;
        end
      end
      ST_STEP2: begin
        if (failed_q) begin
          if (!cmp_lt) begin
            st_q[ST_CONF] <= 1'b1;
            occ_q         <= alu_sum;
          end
        end else begin
          if (cnt_nonpos) begin
            st_q[ST_TF] <= 1'b0;
          end
          if (!cmp_lt) begin
            cnt_q <= pass_thr_q;
          end
        end
      end
      ST_SCAN_CHK: begin
        if (elig && chk_go) begin
          hold_idx_q  <= idx_q;
          hold_st_q   <= ent_rd.st;
          hold_occ_q  <= ent_rd.occ;
          hold_code_q <= code_rd;
        end
        if (chk_go && idx_q != LAST_IDX) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_vld_q;
  assign out_if.ok          = res_q.ok;
  assign out_if.frame       = res_q.frame;
  assign out_if.entry_index = res_q.entry_index;
  assign out_if.status_bits = res_q.status_bits;
  assign out_if.occurrences = res_q.occurrences;
  assign out_if.fault_code  = res_q.fault_code;
  assign out_if.source_id   = res_q.source_id;
  assign out_if.last        = res_q.last;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_if.ready)
    else $error("Request channel stayed ready after a transfer.");

  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.frame) |-> (out_if.ok && out_if.source_id == ecu_id_q))
    else $error("Broadcast frame without ok or with a stale source id.");

  a_hold_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (state_q == ST_SCAN_RD || state_q == ST_SCAN_CHK || state_q == ST_SCAN_END))
    else $error("Held frame outside of a scan.");

  a_frame_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfrm_q <= FRM_LIM)
    else $error("Scan produced more frames than allowed.");

endmodule
